FILE: design/rcsm_pkg.sv
// Shared constants, types and a helper function for the stick setpoint mapper.
package rcsm_pkg;

    localparam int CH_W      = 16;
    localparam int LINE_W    = 11;
    localparam int DB_W      = 9;
    localparam int FULL_W    = 16;
    localparam int THRO_W    = 10;
    localparam int SP_W      = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Quotient bits resolved by the divider, one per pipeline stage.
    localparam int QUO_W     = 16;
    // Remainder width: full scale times deadband-adjusted magnitude.
    localparam int REM_W     = FULL_W + DB_W;
    // Lane depth: front end, multiply, then one stage per quotient bit.
    localparam int LANE_STAGES = 2 + QUO_W;

    localparam logic signed [CH_W-1:0] CH_MIN_S   = 16'sd1000;
    localparam logic signed [CH_W-1:0] CH_MAX_S   = 16'sd2000;
    localparam logic signed [CH_W-1:0] AUX_HOLD_S = 16'sd2000;
    localparam logic [LINE_W-1:0]      CH_MIN     = 11'd1000;
    localparam logic [LINE_W-1:0]      CH_MID     = 11'd1500;
    localparam logic [DB_W-1:0]        CH_HALF    = 9'd500;

    localparam logic [LINE_W-1:0]  LOW_LINE_RST  = 11'd1100;
    localparam logic [LINE_W-1:0]  HIGH_LINE_RST = 11'd1900;
    localparam logic [DB_W-1:0]    DEAD_BAND_RST = 9'd20;
    localparam logic [FULL_W-1:0]  ANGLE_FS_RST  = 16'd3000;
    localparam logic [FULL_W-1:0]  YAW_FS_RST    = 16'd9000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_LINE  = 3'd0,
        CFG_HIGH_LINE = 3'd1,
        CFG_DEAD_BAND = 3'd2,
        CFG_ANGLE_FS  = 3'd3,
        CFG_YAW_FS    = 3'd4
    } cfg_idx_t;

    // Stick-gesture and throttle results that travel beside the lanes.
    typedef struct packed {
        logic [THRO_W-1:0] thro_out;
        logic              unlock_req;
        logic              lock_req;
        logic              calib_req;
        logic              hold_alt;
    } flags_t;

    // Clamp a raw pulse value to 1000..2000; the result always fits 11 bits.
    function automatic logic [LINE_W-1:0] clamp_ch(input logic signed [CH_W-1:0] v);
        logic [LINE_W-1:0] r;
        if (v < CH_MIN_S)
        begin
            r = LINE_W'(CH_MIN_S);
        end
        else if (v > CH_MAX_S)
        begin
            r = LINE_W'(CH_MAX_S);
        end
        else
        begin
            r = v[LINE_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: design/rcsm_if.sv
// Handshake channel interfaces for radio frames and setpoint results.
interface rcsm_frame_if import rcsm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [CH_W-1:0] roll_in;
    logic signed [CH_W-1:0] pitch_in;
    logic signed [CH_W-1:0] thro_in;
    logic signed [CH_W-1:0] yaw_in;
    logic signed [CH_W-1:0] aux_in;
    logic                   imu_ready;

    modport source (output valid, roll_in, pitch_in, thro_in, yaw_in, aux_in, imu_ready,
                    input ready);
    modport sink (input valid, roll_in, pitch_in, thro_in, yaw_in, aux_in, imu_ready,
                  output ready);
endinterface

interface rcsm_setpoint_if import rcsm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [THRO_W-1:0]      thro_out;
    logic signed [SP_W-1:0] roll_sp;
    logic signed [SP_W-1:0] pitch_sp;
    logic signed [SP_W-1:0] yaw_sp;
    logic                   unlock_req;
    logic                   lock_req;
    logic                   calib_req;
    logic                   hold_alt;

    modport source (output valid, thro_out, roll_sp, pitch_sp, yaw_sp, unlock_req,
                    lock_req, calib_req, hold_alt,
                    input ready);
    modport sink (input valid, thro_out, roll_sp, pitch_sp, yaw_sp, unlock_req,
                  lock_req, calib_req, hold_alt,
                  output ready);
endinterface

FILE: design/rcsm_lane.sv
// One axis lane: clamp, deadband, multiply and a bit-per-stage pipelined divider.
module rcsm_lane import rcsm_pkg::*;
(
    input  logic                   clk,
    input  logic [LANE_STAGES-1:0] en,
    input  logic signed [CH_W-1:0] ch,
    input  logic [DB_W-1:0]        dead_band,
    input  logic [FULL_W-1:0]      full_scale,
    output logic signed [SP_W-1:0] sp
);

    logic [LINE_W-1:0] ch_c;
    logic              neg_next;
    logic [DB_W-1:0]   mag;
    logic              zero_next;
    logic [DB_W-1:0]   diff_next;
    logic [DB_W-1:0]   dvs_next;

    logic [DB_W-1:0]   diff_reg;
    logic              fe_neg_reg;
    logic              fe_zero_reg;
    logic [DB_W-1:0]   fe_dvs_reg;

    // Index 0 holds the product; index i holds the state after quotient bit i.
    logic [REM_W-1:0]  rem_reg  [QUO_W+1];
    logic [QUO_W-1:0]  quo_reg  [QUO_W+1];
    logic              neg_reg  [QUO_W+1];
    logic              zero_reg [QUO_W+1];
    logic [DB_W-1:0]   dvs_reg  [QUO_W+1];

    logic [SP_W-1:0]   mag_sp;

    always_comb
    begin
        ch_c     = clamp_ch(ch);
        neg_next = (ch_c < CH_MID);
        if (neg_next)
        begin
            mag = DB_W'(CH_MID - ch_c);
        end
        else
        begin
            mag = DB_W'(ch_c - CH_MID);
        end
        // A deadband of half scale or more leaves no stick travel at all.
        zero_next = (dead_band >= CH_HALF) || (mag <= dead_band);
        diff_next = mag - dead_band;
        dvs_next  = CH_HALF - dead_band;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            diff_reg    <= diff_next;
            fe_neg_reg  <= neg_next;
            fe_zero_reg <= zero_next;
            fe_dvs_reg  <= dvs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            rem_reg[0]  <= REM_W'(full_scale) * REM_W'(diff_reg);
            quo_reg[0]  <= '0;
            neg_reg[0]  <= fe_neg_reg;
            zero_reg[0] <= fe_zero_reg;
            dvs_reg[0]  <= fe_dvs_reg;
        end
    end

    // The quotient never exceeds the full scale, so sixteen restoring steps suffice.
    for (genvar i = 1; i <= QUO_W; i++)
    begin : g_div
        localparam int SH = QUO_W - i;
        logic [REM_W-1:0] trial;
        logic             ge;

        always_comb
        begin
            trial = REM_W'(dvs_reg[i-1]) << SH;
            ge    = (rem_reg[i-1] >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (en[i+1])
            begin
                rem_reg[i]  <= ge ? (rem_reg[i-1] - trial) : rem_reg[i-1];
                quo_reg[i]  <= quo_reg[i-1] | (QUO_W'(ge) << SH);
                neg_reg[i]  <= neg_reg[i-1];
                zero_reg[i] <= zero_reg[i-1];
                dvs_reg[i]  <= dvs_reg[i-1];
            end
        end
    end

    always_comb
    begin
        mag_sp = SP_W'(quo_reg[QUO_W]);
        if (zero_reg[QUO_W])
        begin
            sp = '0;
        end
        else if (neg_reg[QUO_W])
        begin
            sp = -$signed(mag_sp);
        end
        else
        begin
            sp = $signed(mag_sp);
        end
    end

endmodule

FILE: design/rcsm_merge.sv
// Output register that joins the three lane results with the gesture flags.
module rcsm_merge import rcsm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   last_valid,
    input  flags_t                 flags,
    input  logic signed [SP_W-1:0] roll_sp,
    input  logic signed [SP_W-1:0] pitch_sp,
    input  logic signed [SP_W-1:0] yaw_sp,
    rcsm_setpoint_if.source        setpoint
);

    logic                   valid_reg;
    flags_t                 flags_reg;
    logic signed [SP_W-1:0] roll_reg;
    logic signed [SP_W-1:0] pitch_reg;
    logic signed [SP_W-1:0] yaw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= last_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flags_reg <= flags;
            roll_reg  <= roll_sp;
            pitch_reg <= pitch_sp;
            yaw_reg   <= yaw_sp;
        end
    end

    assign setpoint.valid      = valid_reg;
    assign setpoint.thro_out   = flags_reg.thro_out;
    assign setpoint.roll_sp    = roll_reg;
    assign setpoint.pitch_sp   = pitch_reg;
    assign setpoint.yaw_sp     = yaw_reg;
    assign setpoint.unlock_req = flags_reg.unlock_req;
    assign setpoint.lock_req   = flags_reg.lock_req;
    assign setpoint.calib_req  = flags_reg.calib_req;
    assign setpoint.hold_alt   = flags_reg.hold_alt;

endmodule

FILE: design/rc_stick_setpoint_mapper.sv
// Top level of the radio stick to flight setpoint mapper.
//
// One radio frame enters on the frame channel and one setpoint result leaves on
// the setpoint channel for every frame, in order. Both channels use valid/ready;
// a transfer happens on a rising edge with both high.
// Roll, pitch and yaw each run in a lane of their own: clamp and deadband, a
// 16x9 multiply, then a restoring divider that resolves one quotient bit per
// stage. Throttle and the stick-gesture flags ride beside the lanes in a delay
// line, and a merge stage registers everything as one result.
// A frame crosses the front-end, multiply, divider and merge registers before
// its result is valid. A new frame is taken every cycle until a receiver stall
// fills the pipeline; the sixteen divider stages each do one compare and subtract.
// Each stage moves on when it is empty or the stage after it moves, so bubbles
// close up while the receiver stalls and frames keep being taken until every
// stage holds one; ready falls only when the whole pipeline is full.
// Reset clears all stage valid bits and loads the registers with their defaults.
// The user must write registers on the plain port (cfg_we, cfg_idx, cfg_data)
// only while idle; the block does not enforce it. Unused-index writes are dropped.
module rc_stick_setpoint_mapper import rcsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rcsm_frame_if.sink            frame,
    rcsm_setpoint_if.source       setpoint
);

    logic [LINE_W-1:0] low_line_reg;
    logic [LINE_W-1:0] high_line_reg;
    logic [DB_W-1:0]   dead_band_reg;
    logic [FULL_W-1:0] angle_fs_reg;
    logic [FULL_W-1:0] yaw_fs_reg;

    // Stage enables; the top bit advances the output register.
    logic [LANE_STAGES:0]   en;
    logic [LANE_STAGES-1:0] valid_reg;
    flags_t                 flags_reg [LANE_STAGES];
    flags_t                 flags_next;

    logic [LINE_W-1:0] thro_c;
    logic [LINE_W-1:0] roll_c;
    logic [LINE_W-1:0] pitch_c;
    logic              thro_low;
    logic              roll_high;
    logic              pitch_high;

    logic signed [SP_W-1:0] roll_sp;
    logic signed [SP_W-1:0] pitch_sp;
    logic signed [SP_W-1:0] yaw_sp;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_line_reg  <= LOW_LINE_RST;
            high_line_reg <= HIGH_LINE_RST;
            dead_band_reg <= DEAD_BAND_RST;
            angle_fs_reg  <= ANGLE_FS_RST;
            yaw_fs_reg    <= YAW_FS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_idx))
                CFG_LOW_LINE:  low_line_reg  <= cfg_data[LINE_W-1:0];
                CFG_HIGH_LINE: high_line_reg <= cfg_data[LINE_W-1:0];
                CFG_DEAD_BAND: dead_band_reg <= cfg_data[DB_W-1:0];
                CFG_ANGLE_FS:  angle_fs_reg  <= cfg_data[FULL_W-1:0];
                CFG_YAW_FS:    yaw_fs_reg    <= cfg_data[FULL_W-1:0];
                default:       ;
            endcase
        end
    end

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb
    begin
        en[LANE_STAGES] = !setpoint.valid || setpoint.ready;
        for (int k = LANE_STAGES - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign frame.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= frame.valid;
            end
            for (int k = 1; k < LANE_STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Gesture decoding works on the clamped sticks; the lines are compared as given.
    always_comb
    begin
        thro_c     = clamp_ch(frame.thro_in);
        roll_c     = clamp_ch(frame.roll_in);
        pitch_c    = clamp_ch(frame.pitch_in);
        thro_low   = (thro_c < low_line_reg);
        roll_high  = (roll_c > high_line_reg);
        pitch_high = (pitch_c > high_line_reg);

        flags_next.thro_out   = THRO_W'(thro_c - CH_MIN);
        flags_next.calib_req  = thro_low && pitch_high;
        // Calibration in the same frame blocks arming.
        flags_next.unlock_req = thro_low && roll_high && frame.imu_ready && !pitch_high;
        // Roll high wins over roll low when the lines are crossed.
        flags_next.lock_req   = thro_low && !roll_high && (roll_c < low_line_reg);
        flags_next.hold_alt   = (frame.aux_in == AUX_HOLD_S);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            flags_reg[0] <= flags_next;
        end
        for (int k = 1; k < LANE_STAGES; k++)
        begin
            if (en[k])
            begin
                flags_reg[k] <= flags_reg[k-1];
            end
        end
    end

    rcsm_lane u_roll_lane (
        .clk        (clk),
        .en         (en[LANE_STAGES-1:0]),
        .ch         (frame.roll_in),
        .dead_band  (dead_band_reg),
        .full_scale (angle_fs_reg),
        .sp         (roll_sp)
    );

    rcsm_lane u_pitch_lane (
        .clk        (clk),
        .en         (en[LANE_STAGES-1:0]),
        .ch         (frame.pitch_in),
        .dead_band  (dead_band_reg),
        .full_scale (angle_fs_reg),
        .sp         (pitch_sp)
    );

    rcsm_lane u_yaw_lane (
        .clk        (clk),
        .en         (en[LANE_STAGES-1:0]),
        .ch         (frame.yaw_in),
        .dead_band  (dead_band_reg),
        .full_scale (yaw_fs_reg),
        .sp         (yaw_sp)
    );

    rcsm_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (en[LANE_STAGES]),
        .last_valid (valid_reg[LANE_STAGES-1]),
        .flags      (flags_reg[LANE_STAGES-1]),
        .roll_sp    (roll_sp),
        .pitch_sp   (pitch_sp),
        .yaw_sp     (yaw_sp),
        .setpoint   (setpoint)
    );

    // When the output register moves, every stage behind it can move too.
    assert property (@(posedge clk) disable iff (!rst_n)
        en[LANE_STAGES] |-> frame.ready)
        else $error("output advances while the frame channel is blocked");

    // A transferred frame must occupy the first stage on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        frame.valid && frame.ready |=> valid_reg[0])
        else $error("transferred frame lost at the pipeline entry");

    // Input back-pressure arises only when every stage and the output are occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !frame.ready |-> valid_reg[0] && valid_reg[LANE_STAGES-1] && setpoint.valid)
        else $error("frame channel blocked while the pipeline has room");

endmodule
